[sv/greedy_gc_victim_bucket_lists_core_defines.svh]
// Assertion macros used by the victim tracker controller.
`ifndef GREEDY_GC_VICTIM_BUCKET_LISTS_CORE_DEFINES_SVH
`define GREEDY_GC_VICTIM_BUCKET_LISTS_CORE_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define GGC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GGC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[sv/ggc_vbl_pkg.sv]
// Package with types and constants of the victim tracker.
package ggc_vbl_pkg;
   localparam int NUM_DIES_C = 8;
   localparam int BLOCKS_PER_DIE_C = 1024;
   localparam int SLICES_PER_BLOCK_C = 128;
   localparam int FUNC_W = 2;
   localparam int DIE_W = 3;
   localparam int BLOCK_W = 10;
   localparam int BUCKET_W = 8;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

   // Controller to datapath commands, one-hot in effect.
   typedef struct packed {
      logic clear;       // clear one tail table entry after reset
      logic capture;     // take the request fields
      logic scan;        // register nonempty bitmap scan result
      logic rd_heads;    // read head and tail of the list
      logic rd_nbr;      // read links (already in rd stage)
      logic write;       // perform the list update
      logic load_rsp;    // load response register
   } ggc_cmd_type;

   typedef struct packed {
      logic done;
   } ggc_sts_type;
endpackage

[sv/ggc_vbl_datapath.sv]
// Datapath of the victim tracker: list tables, link memories and bitmap.
module ggc_vbl_datapath
   import ggc_vbl_pkg::*;
#(
   parameter int NUM_DIES = NUM_DIES_C,
   parameter int BLOCKS_PER_DIE = BLOCKS_PER_DIE_C,
   parameter int SLICES_PER_BLOCK_P = SLICES_PER_BLOCK_C
) (
   input  logic                clock,
   input  logic                reset,
   input  ggc_cmd_type         cmd,
   output ggc_sts_type         sts,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [DIE_W-1:0]    req_die,
   input  logic [BLOCK_W-1:0]  req_block,
   input  logic [BUCKET_W-1:0] req_bucket,
   output logic [BLOCK_W-1:0]  rsp_victim_block_ff,
   output logic                rsp_status_ff
);
   localparam int NB = SLICES_PER_BLOCK_P + 1;
   localparam int LD = NUM_DIES * NB;
   localparam int KD = NUM_DIES * BLOCKS_PER_DIE;
   localparam int LW = (LD > 1) ? $clog2(LD) : 1;
   localparam int KW = (KD > 1) ? $clog2(KD) : 1;
   localparam int BW = $clog2(BLOCKS_PER_DIE);
   localparam int CW = $clog2(NB + 1);
   localparam int DW = (NUM_DIES > 1) ? $clog2(NUM_DIES) : 1;

   // Memories: heads with a per-list nonempty bit, tails with their own valid
   // bit (cleared after reset), links undefined until written.
   logic [BW-1:0] head_mem [LD];
   logic [BW:0]   tail_mem [LD];
   logic [BW:0]   next_mem [KD];
   logic [BW:0]   prev_mem [KD];
   logic [NB-1:0] nonempty_ff [NUM_DIES];

   logic [FUNC_W-1:0] func_ff;
   logic [DW-1:0]     die_ff;
   logic [BW-1:0]     blk_ff;
   logic [CW-1:0]     bkt_ff;
   logic              ok_ff;
   logic [BW-1:0]     head_rd_ff;
   logic [BW:0]       tail_rd_ff;
   logic [BW:0]       nxt_rd_ff, prv_rd_ff;
   logic [LW-1:0]     clr_ff;

   logic [CW-1:0] top_in;
   logic          found_in;

   // Priority encoder over counts max..1 of the selected die.
   always_comb begin
      logic [NB-1:0] v;
      v = nonempty_ff[die_ff];
      top_in = '0;
      found_in = 1'b0;
      for (int c = 1; c < NB; c++) begin
         if (v[c]) begin
            top_in = CW'(c);
            found_in = 1'b1;
         end
      end
   end

   logic [BW-1:0] rd_blk;
   assign rd_blk = (func_ff == FUNC_POP) ? head_rd_ff : blk_ff;

   function automatic logic [LW-1:0] lidx(input logic [DW-1:0] d, input logic [CW-1:0] c);
      return LW'(d * NB + c);
   endfunction
   function automatic logic [KW-1:0] kidx(input logic [DW-1:0] d, input logic [BW-1:0] b);
      return KW'(d * BLOCKS_PER_DIE + b);
   endfunction

   // Address counter of the tail table clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + LW'(1);
      end
   end

   assign sts.done = (clr_ff == LW'(LD - 1));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         die_ff <= DW'(req_die);
         blk_ff <= BW'(req_block);
         bkt_ff <= CW'(req_bucket);
         if (req_func == FUNC_POP) begin
            ok_ff <= (32'(req_die) < NUM_DIES);
         end else begin
            ok_ff <= (32'(req_die) < NUM_DIES) && (32'(req_block) < BLOCKS_PER_DIE)
                     && (32'(req_bucket) <= SLICES_PER_BLOCK_P);
         end
      end
      if (cmd.scan) begin
         if (func_ff == FUNC_POP) begin
            bkt_ff <= top_in;
            ok_ff <= found_in && ok_ff;
         end
      end
      if (cmd.rd_heads) begin
         head_rd_ff <= head_mem[lidx(die_ff, bkt_ff)];
         tail_rd_ff <= tail_mem[lidx(die_ff, bkt_ff)];
      end
      if (cmd.rd_nbr) begin
         nxt_rd_ff <= next_mem[kidx(die_ff, rd_blk)];
         prv_rd_ff <= prev_mem[kidx(die_ff, rd_blk)];
      end
   end

   // Pop validity is die range plus bitmap hit.
   logic pop_ok;
   assign pop_ok = ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         tail_mem[clr_ff] <= '0;
      end else if (cmd.write && ok_ff) begin
         case (func_ff)
            FUNC_INSERT: begin
               next_mem[kidx(die_ff, blk_ff)] <= '0;
               tail_mem[lidx(die_ff, bkt_ff)] <= {1'b1, blk_ff};
               if (tail_rd_ff[BW]) begin
                  prev_mem[kidx(die_ff, blk_ff)] <= tail_rd_ff;
                  next_mem[kidx(die_ff, tail_rd_ff[BW-1:0])] <= {1'b1, blk_ff};
               end else begin
                  prev_mem[kidx(die_ff, blk_ff)] <= '0;
                  head_mem[lidx(die_ff, bkt_ff)] <= blk_ff;
               end
            end
            FUNC_POP: begin
               if (nxt_rd_ff[BW]) begin
                  prev_mem[kidx(die_ff, nxt_rd_ff[BW-1:0])] <= '0;
                  head_mem[lidx(die_ff, bkt_ff)] <= nxt_rd_ff[BW-1:0];
               end else begin
                  tail_mem[lidx(die_ff, bkt_ff)] <= '0;
               end
            end
            FUNC_REMOVE: begin
               if (nxt_rd_ff[BW] && prv_rd_ff[BW]) begin
                  next_mem[kidx(die_ff, prv_rd_ff[BW-1:0])] <= nxt_rd_ff;
                  prev_mem[kidx(die_ff, nxt_rd_ff[BW-1:0])] <= prv_rd_ff;
               end else if (prv_rd_ff[BW]) begin
                  next_mem[kidx(die_ff, prv_rd_ff[BW-1:0])] <= '0;
                  tail_mem[lidx(die_ff, bkt_ff)] <= prv_rd_ff;
               end else if (nxt_rd_ff[BW]) begin
                  prev_mem[kidx(die_ff, nxt_rd_ff[BW-1:0])] <= '0;
                  head_mem[lidx(die_ff, bkt_ff)] <= nxt_rd_ff[BW-1:0];
               end else begin
                  tail_mem[lidx(die_ff, bkt_ff)] <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_DIES; d++) nonempty_ff[d] <= '0;
      end else if (cmd.write && ok_ff) begin
         case (func_ff)
            FUNC_INSERT: if (!tail_rd_ff[BW]) nonempty_ff[die_ff][bkt_ff] <= 1'b1;
            FUNC_POP: if (!nxt_rd_ff[BW]) nonempty_ff[die_ff][bkt_ff] <= 1'b0;
            FUNC_REMOVE: begin
               if (nxt_rd_ff[BW] && !prv_rd_ff[BW]) nonempty_ff[die_ff][bkt_ff] <= 1'b1;
               else if (!nxt_rd_ff[BW] && !prv_rd_ff[BW]) nonempty_ff[die_ff][bkt_ff] <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (func_ff == FUNC_POP) begin
            rsp_victim_block_ff <= pop_ok ? BLOCK_W'(head_rd_ff) : '0;
            rsp_status_ff <= !pop_ok;
         end else begin
            rsp_victim_block_ff <= '0;
            rsp_status_ff <= 1'b0;
         end
      end
   end
endmodule

[sv/ggc_vbl_ctrl.sv]
// Controller state machine of the victim tracker.
module ggc_vbl_ctrl
   import ggc_vbl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  ggc_sts_type sts,
   output ggc_cmd_type cmd
);
`include "greedy_gc_victim_bucket_lists_core_defines.svh"
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SCAN  = 7'b0000010,
      ST_HEADS = 7'b0000100,
      ST_LINKS = 7'b0001000,
      ST_WRITE = 7'b0010000,
      ST_RESP  = 7'b0100000,
      ST_CLEAR = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.capture = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = ST_HEADS;
         end
         ST_HEADS: begin
            cmd.rd_heads = 1'b1;
            state_in = ST_LINKS;
         end
         ST_LINKS: begin
            cmd.rd_nbr = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // The result register is loaded once the previous beat has left.
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `GGC_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, req_stall)
   `GGC_ASSERT_NXT(a_resp_sets_valid, clock, reset, state_ff == ST_RESP, rsp_valid_ff)
   `GGC_ASSERT_NXT(a_accept_scans, clock, reset, req_valid && !req_stall, state_ff == ST_SCAN)
   `GGC_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff)
endmodule

[sv/greedy_gc_victim_bucket_lists_core.sv]
// Top level of the greedy garbage-collection victim tracker.
// Each request beat passes from acceptance to the result beat through one
// capture, one scan of the per-die nonempty bitmap through a priority encoder,
// one head/tail table read, one link read, one list update and one result
// load, in that order. A new request is taken only once the previous one has
// loaded its result, as req_stall stays high until then. The result waits in its
// own register, so a stalled result beat only holds back the following item
// when that item's result is due while the earlier beat still waits. Insert
// appends a block to its count's list, pop takes the head of the highest
// nonempty count above zero (status 1 when none), remove unlinks a named
// block. Reset empties every list head at once through the bitmap; the tail
// table is then cleared one entry a cycle, during which req_stall stays high.
// The link tables need no clear.
module greedy_gc_victim_bucket_lists_core
   import ggc_vbl_pkg::*;
#(
   parameter int NUM_DIES = NUM_DIES_C,
   parameter int BLOCKS_PER_DIE = BLOCKS_PER_DIE_C,
   parameter int SLICES_PER_BLOCK_P = SLICES_PER_BLOCK_C
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [DIE_W-1:0]    req_die,
   input  logic [BLOCK_W-1:0]  req_block,
   input  logic [BUCKET_W-1:0] req_bucket,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BLOCK_W-1:0]  rsp_victim_block,
   output logic                rsp_status
);
   ggc_cmd_type cmd;
   ggc_sts_type sts;

   ggc_vbl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   ggc_vbl_datapath #(
      .NUM_DIES(NUM_DIES), .BLOCKS_PER_DIE(BLOCKS_PER_DIE),
      .SLICES_PER_BLOCK_P(SLICES_PER_BLOCK_P)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_func(req_func), .req_die(req_die), .req_block(req_block),
      .req_bucket(req_bucket),
      .rsp_victim_block_ff(rsp_victim_block), .rsp_status_ff(rsp_status)
   );
endmodule
